### hw/rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// shared types, constants and helpers of the keyed polybius square codec
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int GRID_SIDE   = 5;
    localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int CELL_IDX_W  = $clog2(GRID_CELLS);
    localparam int SIDE_W      = $clog2(GRID_SIDE);
    localparam int CHAR_W      = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int KEY_BYTES   = CFG_DATA_W / CHAR_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE     = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KEY_FIRST    = 3'd0,
        CFG_KEY_SECOND   = 3'd1,
        CFG_KEY_THIRD    = 3'd2,
        CFG_KEY_FINAL    = 3'd3,
        CFG_DECRYPT_MODE = 3'd4
    } kpc_cfg_idx_t;

    // one queued job: one or two result bytes of one input transfer
    typedef struct packed {
        logic              two;
        logic [CHAR_W-1:0] first_char;
        logic [CHAR_W-1:0] second_char;
        logic              pair_err;
        logic              eom;
    } kpc_job_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } kpc_queue_stat_t;

    function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

### hw/rtl/kpc_front.sv
// ----------------------------------------------------------------------------
// kpc_front
// config registers, input acceptance and classification of each byte into
// a job of one or two result bytes
// ----------------------------------------------------------------------------
module kpc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [kpc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [kpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kpc_pkg::CHAR_W-1:0]          s_tdata,
    input  logic                                s_tlast,
    input  kpc_pkg::kpc_queue_stat_t            q_stat,
    output logic                                q_push,
    output kpc_pkg::kpc_job_t                   q_job
);

    logic [kpc_pkg::CHAR_W-1:0] key_cells_reg [kpc_pkg::GRID_CELLS];
    logic [kpc_pkg::CHAR_W-1:0] key_cells_next [kpc_pkg::GRID_CELLS];
    logic                       decrypt_mode_reg, decrypt_mode_next;
    logic                       digit_held_reg, digit_held_next;
    logic [kpc_pkg::CHAR_W-1:0] held_digit_reg, held_digit_next;

    logic                       accept;
    logic [kpc_pkg::CHAR_W-1:0] up_char;
    logic                       hit;
    logic [kpc_pkg::SIDE_W-1:0] hit_row, hit_col;
    logic [kpc_pkg::CHAR_W-1:0] row_off, col_off;
    logic                       pair_in_grid;
    logic [kpc_pkg::CELL_IDX_W-1:0] pair_idx;
    logic                       in_digit;
    logic                       hold_now;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign in_digit = kpc_pkg::is_digit(s_tdata);
    assign hold_now = decrypt_mode_reg && !digit_held_reg && in_digit && !s_tlast;
    assign q_push   = accept && !hold_now;

    // grid search, later position wins
    always_comb begin
        up_char = kpc_pkg::upcase(s_tdata);
        hit     = 1'b0;
        hit_row = '0;
        hit_col = '0;
        for (int r = 0; r < kpc_pkg::GRID_SIDE; r++) begin
            for (int c = 0; c < kpc_pkg::GRID_SIDE; c++) begin
                if (kpc_pkg::upcase(key_cells_reg[r*kpc_pkg::GRID_SIDE + c]) == up_char) begin
                    hit     = 1'b1;
                    hit_row = kpc_pkg::SIDE_W'(r);
                    hit_col = kpc_pkg::SIDE_W'(c);
                end
            end
        end
    end

    // digit pair to cell index
    always_comb begin
        row_off      = held_digit_reg - kpc_pkg::CHAR_ONE;
        col_off      = s_tdata - kpc_pkg::CHAR_ONE;
        pair_in_grid = (row_off < kpc_pkg::CHAR_W'(kpc_pkg::GRID_SIDE))
                    && (col_off < kpc_pkg::CHAR_W'(kpc_pkg::GRID_SIDE));
        pair_idx     = kpc_pkg::CELL_IDX_W'(row_off[kpc_pkg::SIDE_W-1:0])
                     * kpc_pkg::CELL_IDX_W'(kpc_pkg::GRID_SIDE)
                     + kpc_pkg::CELL_IDX_W'(col_off[kpc_pkg::SIDE_W-1:0]);
    end

    // job contents
    always_comb begin
        q_job.two         = 1'b0;
        q_job.first_char  = s_tdata;
        q_job.second_char = s_tdata;
        q_job.pair_err    = 1'b0;
        q_job.eom         = s_tlast;
        if (!decrypt_mode_reg) begin
            if (hit) begin
                q_job.two         = 1'b1;
                q_job.first_char  = kpc_pkg::CHAR_ONE + kpc_pkg::CHAR_W'(hit_row);
                q_job.second_char = kpc_pkg::CHAR_ONE + kpc_pkg::CHAR_W'(hit_col);
            end
        end else if (digit_held_reg) begin
            if (in_digit) begin
                if (pair_in_grid) begin
                    q_job.first_char = kpc_pkg::upcase(key_cells_reg[pair_idx]);
                end else begin
                    q_job.first_char = '0;
                    q_job.pair_err   = 1'b1;
                end
            end else begin
                q_job.two        = 1'b1;
                q_job.first_char = held_digit_reg;
            end
        end
    end

    // config writes and held digit
    always_comb begin
        key_cells_next    = key_cells_reg;
        decrypt_mode_next = decrypt_mode_reg;
        digit_held_next   = digit_held_reg;
        held_digit_next   = held_digit_reg;
        if (accept && decrypt_mode_reg) begin
            if (digit_held_reg) begin
                digit_held_next = 1'b0;
                held_digit_next = '0;
            end else if (hold_now) begin
                digit_held_next = 1'b1;
                held_digit_next = s_tdata;
            end
        end
        if (cfg_we) begin
            unique case (kpc_pkg::kpc_cfg_idx_t'(cfg_addr))
                kpc_pkg::CFG_KEY_FIRST, kpc_pkg::CFG_KEY_SECOND,
                kpc_pkg::CFG_KEY_THIRD: begin
                    for (int j = 0; j < kpc_pkg::GRID_CELLS - 1; j++) begin
                        if (cfg_addr == kpc_pkg::CFG_ADDR_W'(j / kpc_pkg::KEY_BYTES)) begin
                            key_cells_next[j] =
                                cfg_wdata[(j % kpc_pkg::KEY_BYTES)*kpc_pkg::CHAR_W +:
                                          kpc_pkg::CHAR_W];
                        end
                    end
                end
                kpc_pkg::CFG_KEY_FINAL: begin
                    key_cells_next[kpc_pkg::GRID_CELLS-1] = cfg_wdata[kpc_pkg::CHAR_W-1:0];
                end
                kpc_pkg::CFG_DECRYPT_MODE: begin
                    decrypt_mode_next = cfg_wdata[0];
                    digit_held_next   = 1'b0;
                    held_digit_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < kpc_pkg::GRID_CELLS; j++) begin
                key_cells_reg[j] <= '0;
            end
            decrypt_mode_reg <= 1'b0;
            digit_held_reg   <= 1'b0;
            held_digit_reg   <= '0;
        end else begin
            key_cells_reg    <= key_cells_next;
            decrypt_mode_reg <= decrypt_mode_next;
            digit_held_reg   <= digit_held_next;
            held_digit_reg   <= held_digit_next;
        end
    end

endmodule

### hw/rtl/kpc_queue.sv
// ----------------------------------------------------------------------------
// kpc_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module kpc_queue #(
    parameter int DEPTH = kpc_pkg::QUEUE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  kpc_pkg::kpc_job_t        push_job,
    input  logic                     pop,
    output kpc_pkg::kpc_job_t        head_job,
    output kpc_pkg::kpc_queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kpc_pkg::kpc_job_t entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign do_push        = push && !stat.full;
    assign do_pop         = pop && stat.not_empty;
    assign head_job       = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hw/rtl/kpc_back.sv
// ----------------------------------------------------------------------------
// kpc_back
// unpacks queued jobs into result transfers through an output register
// ----------------------------------------------------------------------------
module kpc_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  kpc_pkg::kpc_queue_stat_t   q_stat,
    input  kpc_pkg::kpc_job_t          q_job,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [kpc_pkg::CHAR_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic [1:0]                 m_tuser
);

    logic                       phase_reg, phase_next;
    logic                       valid_reg, valid_next;
    logic [kpc_pkg::CHAR_W-1:0] data_reg, data_next;
    logic                       run_last_reg, run_last_next;
    logic                       done_reg, done_next;
    logic                       err_reg, err_next;
    logic                       load;

    assign load = q_stat.not_empty && (!valid_reg || m_tready);

    always_comb begin
        phase_next    = phase_reg;
        valid_next    = valid_reg;
        data_next     = data_reg;
        run_last_next = run_last_reg;
        done_next     = done_reg;
        err_next      = err_reg;
        q_pop         = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (!phase_reg && q_job.two) begin
                data_next     = q_job.first_char;
                run_last_next = 1'b0;
                done_next     = 1'b0;
                err_next      = 1'b0;
                phase_next    = 1'b1;
            end else begin
                data_next     = phase_reg ? q_job.second_char : q_job.first_char;
                run_last_next = 1'b1;
                done_next     = q_job.eom;
                err_next      = phase_reg ? 1'b0 : q_job.pair_err;
                phase_next    = 1'b0;
                q_pop         = 1'b1;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg     <= data_next;
        run_last_reg <= run_last_next;
        done_reg     <= done_next;
        err_reg      <= err_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = done_reg;
    assign m_tuser  = {err_reg, run_last_reg};

endmodule

### hw/rtl/keyed_polybius_square_codec_top.sv
// ----------------------------------------------------------------------------
// keyed_polybius_square_codec_top
// keyed 5x5 polybius square encoder and decoder on a byte stream
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the job queue is not full and
// hands out one result per cycle while the receiver is ready. An encrypted
// grid character gives two digits and so holds the single result port
// longer than a byte that gives one result. A first digit in decrypt mode
// that does not end the message gives no result. The first result of a
// byte passes through the job queue and then the output register; the job
// queue between the classifier and the output register decides how far the
// two sides may drift before the input side stalls. The user must write the
// key and mode registers only while idle; the block does not enforce this.
module keyed_polybius_square_codec_top #(
    parameter int QUEUE_DEPTH = kpc_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [kpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] char_in
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] char_out
    output logic                           m_tlast,
    output logic [1:0]                     m_tuser    // [0] last_of_run, [1] pair_error
);

    kpc_pkg::kpc_queue_stat_t q_stat;
    kpc_pkg::kpc_job_t        push_job, head_job;
    logic                     q_push, q_pop;

    kpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    kpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    kpc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### hw/rtl/kpc_checker.sv
// ----------------------------------------------------------------------------
// kpc_checker
// port level checks of the keyed polybius square codec
// ----------------------------------------------------------------------------
module kpc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // a bad pair gives a zero byte closing its run
    a_pair_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 8'h00 && m_tuser[0])
        else $error("pair error with bad byte or not last of run");

    // message end only on the last result of a run
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("message end not on last of run");

endmodule

bind keyed_polybius_square_codec_top kpc_checker u_kpc_checker (.*);

### tb/keyed_polybius_square_codec_top_test.sv
// ----------------------------------------------------------------------------
// keyed_polybius_square_codec_top_test
// self-checking testbench of the keyed 5x5 polybius square codec
// ----------------------------------------------------------------------------
// Drives byte messages into the stream input in bursts with random gaps while
// the result side stalls on its own pattern. A behavioral model of the grid,
// the mode and the held digit predicts every result of each accepted
// transfer; results are checked field by field in arrival order. Directed
// tests cover the reset grid, key case, repeated key characters, pairs
// outside the grid, held digits and mode changes; random phases then walk
// through several keys and both modes.
// ----------------------------------------------------------------------------
module keyed_polybius_square_codec_top_test;

    import kpc_pkg::*;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_UP_A  = 8'h41;
    localparam logic [7:0] ASCII_UP_Z  = 8'h5a;
    localparam logic [7:0] ASCII_LOW_A = 8'h61;
    localparam logic [7:0] ASCII_LOW_Z = 8'h7a;
    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam logic [7:0] NOT_DIGIT   = 8'h40;

    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 50000;

    typedef enum int {
        KEY_ALPHABET,
        KEY_RANDOM,
        KEY_REPEATS,
        KEY_ALL_ZERO,
        KEY_ALL_ONES
    } key_style_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_RUNS
    } rx_style_t;

    typedef logic [7:0] grid_t [GRID_CELLS];

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_of_run;
        logic       message_done;
        logic       pair_error;
    } codec_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;

    keyed_polybius_square_codec_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] char_in
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] char_out
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)     // [0] last_of_run, [1] pair_error
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // codec model state
    grid_t      grid_model;
    logic       decrypt_on;
    logic       digit_waiting;
    logic [7:0] waiting_digit;

    codec_result_t expected_results[$];
    int            mismatch_count = 0;

    int        burst_left = 0;
    bit        tx_gaps_on = 1'b1;
    rx_style_t rx_style = RX_ALWAYS;
    bit        rx_open = 1'b1;
    int        rx_left = 0;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= ASCII_LOW_A && c <= ASCII_LOW_Z) begin
            return c - CASE_BIT;
        end
        return c;
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= ASCII_ZERO && c <= ASCII_NINE;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= ASCII_UP_A && c <= ASCII_UP_Z) || (c >= ASCII_LOW_A && c <= ASCII_LOW_Z);
    endfunction

    task automatic push_result(input logic [7:0] c, input logic err);
        codec_result_t r;
        r.char_out = c;
        r.last_of_run = 1'b0;
        r.message_done = 1'b0;
        r.pair_error = err;
        expected_results.push_back(r);
    endtask

    task automatic predict_codec(input logic [7:0] c, input logic eom);
        int found;
        int row;
        int col;
        int before_count;
        int last;
        before_count = expected_results.size();
        if (!decrypt_on) begin
            found = -1;
            for (int i = 0; i < GRID_CELLS; i++) begin
                if (to_upper(grid_model[i]) == to_upper(c)) begin
                    found = i;
                end
            end
            if (found >= 0) begin
                push_result(ASCII_ZERO + 8'(found / GRID_SIDE + 1), 1'b0);
                push_result(ASCII_ZERO + 8'(found % GRID_SIDE + 1), 1'b0);
            end else begin
                push_result(c, 1'b0);
            end
        end else if (digit_waiting) begin
            if (is_numeral(c)) begin
                row = int'(waiting_digit - ASCII_ZERO);
                col = int'(c - ASCII_ZERO);
                if (row >= 1 && row <= GRID_SIDE && col >= 1 && col <= GRID_SIDE) begin
                    push_result(to_upper(grid_model[(row - 1) * GRID_SIDE + col - 1]), 1'b0);
                end else begin
                    push_result(8'h00, 1'b1);
                end
            end else begin
                push_result(waiting_digit, 1'b0);
                push_result(c, 1'b0);
            end
            digit_waiting = 1'b0;
            waiting_digit = 8'h00;
        end else if (is_numeral(c) && !eom) begin
            digit_waiting = 1'b1;
            waiting_digit = c;
        end else begin
            push_result(c, 1'b0);
        end
        if (expected_results.size() > before_count) begin
            last = expected_results.size() - 1;
            expected_results[last].last_of_run = 1'b1;
            expected_results[last].message_done = eom;
        end
    endtask

    task automatic report_failure(input string what, input codec_result_t want,
                                  input codec_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected char %h last %b done %b err %b, got char %h last %b done %b err %b",
                     $realtime, what, want.char_out, want.last_of_run, want.message_done,
                     want.pair_error, got.char_out, got.last_of_run, got.message_done,
                     got.pair_error);
        end
    endtask

    // result checking and receiver stall pattern
    always @(posedge aclk) begin
        codec_result_t got;
        codec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.char_out = m_tdata;
            got.last_of_run = m_tuser[0];
            got.message_done = m_tlast;
            got.pair_error = m_tuser[1];
            if (expected_results.size() == 0) begin
                report_failure("unexpected transfer", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    report_failure("mismatch", want, got);
                end
            end
        end
        case (rx_style)
            RX_ALWAYS: begin
                m_tready <= 1'b1;
            end
            RX_COIN: begin
                m_tready <= ($urandom_range(0, 99) < 65);
            end
            default: begin
                if (rx_left == 0) begin
                    rx_open = !rx_open;
                    rx_left = rx_open ? $urandom_range(1, 10) : $urandom_range(1, 12);
                end
                rx_left--;
                m_tready <= rx_open;
            end
        endcase
    end

    task automatic send_byte(input logic [7:0] c, input logic eom);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tx_gaps_on) begin
                gap = $urandom_range(1, 7);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= eom;
        do @(posedge aclk); while (!s_tready);
        predict_codec(c, eom);
        burst_left--;
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_we high, the caller lowers it after the last write
    task automatic write_reg(input kpc_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_KEY_FIRST, CFG_KEY_SECOND, CFG_KEY_THIRD: begin
                for (int b = 0; b < KEY_BYTES; b++) begin
                    grid_model[int'(idx) * KEY_BYTES + b] = value[8 * b +: 8];
                end
            end
            CFG_KEY_FINAL: begin
                grid_model[GRID_CELLS - 1] = value[7:0];
            end
            CFG_DECRYPT_MODE: begin
                decrypt_on = value[0];
                digit_waiting = 1'b0;
                waiting_digit = 8'h00;
            end
            default: ;
        endcase
    endtask

    task automatic configure_codec(input grid_t cells, input logic decrypt, input bit load_key);
        logic [CFG_DATA_W-1:0] word;
        int start;
        int idx;
        settle_block();
        if (load_key) begin
            start = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++) begin
                idx = (start + k) % 4;
                word = '0;
                if (idx == int'(CFG_KEY_FINAL)) begin
                    word[7:0] = cells[GRID_CELLS - 1];
                end else begin
                    for (int b = 0; b < KEY_BYTES; b++) begin
                        word[8 * b +: 8] = cells[idx * KEY_BYTES + b];
                    end
                end
                write_reg(kpc_cfg_idx_t'(idx), word);
            end
        end
        write_reg(CFG_DECRYPT_MODE, {{(CFG_DATA_W-1){1'b0}}, decrypt});
        cfg_we <= 1'b0;
    endtask

    function automatic grid_t make_key(input key_style_t style);
        grid_t cells;
        logic [7:0] ch;
        logic [7:0] t;
        int j;
        ch = ASCII_UP_A;
        for (int i = 0; i < GRID_CELLS; i++) begin
            if (ch == "J") ch++;
            case (style)
                KEY_ALPHABET: cells[i] = ch;
                KEY_RANDOM:   cells[i] = 8'($urandom_range(0, 255));
                KEY_REPEATS:  cells[i] = "A" + 8'($urandom_range(0, 3));
                KEY_ALL_ZERO: cells[i] = 8'h00;
                default:      cells[i] = 8'hff;
            endcase
            ch++;
        end
        if (style == KEY_ALPHABET) begin
            for (int i = GRID_CELLS - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                t = cells[i];
                cells[i] = cells[j];
                cells[j] = t;
            end
        end
        if (style == KEY_ALPHABET || style == KEY_REPEATS) begin
            for (int i = 0; i < GRID_CELLS; i++) begin
                if ($urandom_range(0, 1)) cells[i] = cells[i] | CASE_BIT;
            end
        end
        return cells;
    endfunction

    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] b;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            b = grid_model[$urandom_range(0, GRID_CELLS - 1)];
            if (is_letter(b) && $urandom_range(0, 1)) b = b ^ CASE_BIT;
        end else if (pick < 70) begin
            b = ($urandom_range(0, 1) ? ASCII_UP_A : ASCII_LOW_A) + 8'($urandom_range(0, 25));
        end else begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    task automatic build_cipher_message(ref logic [7:0] msg[$]);
        int pick;
        logic [7:0] b;
        int pieces;
        pieces = $urandom_range(1, 6);
        for (int p = 0; p < pieces; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                msg.push_back(ASCII_ZERO + 8'($urandom_range(1, GRID_SIDE)));
                msg.push_back(ASCII_ZERO + 8'($urandom_range(1, GRID_SIDE)));
            end else if (pick < 75) begin
                msg.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
                msg.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
            end else if (pick < 85) begin
                msg.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
                b = 8'($urandom_range(0, 255));
                if (is_numeral(b)) b = b ^ NOT_DIGIT;
                msg.push_back(b);
            end else begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_random_phase(input logic decrypt, input key_style_t style,
                                    input int item_count);
        logic [7:0] msg[$];
        int sent;
        int len;
        int pause_at;
        configure_codec(make_key(style), decrypt, 1'b1);
        rx_style = rx_style_t'($urandom_range(0, 2));
        tx_gaps_on = $urandom_range(0, 3) != 0;
        pause_at = $urandom_range(item_count / 4, item_count / 2);
        sent = 0;
        while (sent < item_count) begin
            msg.delete();
            if (decrypt) begin
                build_cipher_message(msg);
            end else begin
                len = $urandom_range(1, 10);
                repeat (len) msg.push_back(pick_plain_byte());
            end
            for (int i = 0; i < msg.size() && sent < item_count; i++) begin
                send_byte(msg[i], i == msg.size() - 1);
                sent++;
                if (sent == pause_at) settle_block();
            end
        end
    endtask

    task automatic test_reset_defaults();
        rx_style = RX_ALWAYS;
        tx_gaps_on = 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte("A", 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_encrypt_directed();
        grid_t cells;
        cells = make_key(KEY_ALL_ZERO);
        begin
            logic [7:0] ch;
            ch = ASCII_UP_A;
            for (int i = 0; i < GRID_CELLS; i++) begin
                if (ch == "J") ch++;
                cells[i] = (i < GRID_SIDE) ? (ch | CASE_BIT) : ch;
                ch++;
            end
        end
        // later copy of the first letter, also lower case
        cells[GRID_CELLS - 1] = "a";
        configure_codec(cells, 1'b0, 1'b1);
        rx_style = RX_COIN;
        tx_gaps_on = 1'b1;
        send_byte("a", 1'b0);
        send_byte("A", 1'b0);
        send_byte("b", 1'b0);
        send_byte("Y", 1'b0);
        send_byte("Z", 1'b0);
        send_byte("j", 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte("5", 1'b1);
    endtask

    task automatic test_decrypt_directed();
        configure_codec(grid_model, 1'b1, 1'b0);
        rx_style = RX_RUNS;
        send_byte("1", 1'b0);
        send_byte("1", 1'b0);
        send_byte("5", 1'b0);
        send_byte("5", 1'b0);
        send_byte("0", 1'b0);
        send_byte("3", 1'b0);
        send_byte("6", 1'b0);
        send_byte("1", 1'b0);
        send_byte("9", 1'b0);
        send_byte("9", 1'b0);
        send_byte("2", 1'b0);
        send_byte("x", 1'b0);
        send_byte("Q", 1'b0);
        send_byte("3", 1'b0);
        send_byte("4", 1'b1);
        send_byte("7", 1'b1);
        send_byte(8'hff, 1'b1);
        // held digit dropped by a mode write
        send_byte("4", 1'b0);
        configure_codec(grid_model, 1'b1, 1'b0);
        send_byte("2", 1'b0);
        send_byte("3", 1'b1);
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b0, KEY_ALPHABET, 80);
        run_random_phase(1'b1, KEY_ALPHABET, 80);
        run_random_phase(1'b0, KEY_REPEATS, 80);
        run_random_phase(1'b1, KEY_RANDOM, 80);
        run_random_phase(1'b0, KEY_ALL_ONES, 80);
        run_random_phase(1'b1, KEY_ALL_ZERO, 80);
        run_random_phase(1'b0, KEY_RANDOM, 80);
        run_random_phase(1'b1, KEY_REPEATS, 80);
    endtask

    initial begin
        for (int i = 0; i < GRID_CELLS; i++) grid_model[i] = 8'h00;
        decrypt_on = 1'b0;
        digit_waiting = 1'b0;
        waiting_digit = 8'h00;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_encrypt_directed();
        test_decrypt_directed();
        test_random_traffic();

        s_tvalid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && expected_results.size() != 0; k++) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $realtime,
                     expected_results.size());
        end
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_front.sv
hw/rtl/kpc_queue.sv
hw/rtl/kpc_back.sv
hw/rtl/keyed_polybius_square_codec_top.sv
hw/rtl/kpc_checker.sv
tb/keyed_polybius_square_codec_top_test.sv
